// ===== rtl/rd_pkg.sv =====
// Shared constants for the pipelined restoring divider.
// No dependencies; imported by rd_stage and restoring_divider.
package rd_pkg;

  // Default operand width of the division datapath.
  localparam int unsigned RD_WIDTH_DEF = 32;

  // Width of every numeric field on the stream ports.
  localparam int unsigned FIELD_W = 32;

  // Stream payload widths: two 32-bit fields per channel, already byte aligned.
  localparam int unsigned IN_TDATA_W  = 2 * FIELD_W;
  localparam int unsigned OUT_TDATA_W = 2 * FIELD_W;
  localparam int unsigned OUT_TUSER_W = 1;

endpackage : rd_pkg

// ===== rtl/rd_stage.sv =====
// One restoring-division round as a pipeline register stage.
// Depends on rd_pkg (only the shared default width); instantiated by restoring_divider.
module rd_stage
  import rd_pkg::*;
#(
  parameter int unsigned WIDTH = RD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,      // advance the whole pipe
  input  logic             valid_i,
  input  logic [WIDTH-1:0] acc_i,    // partial remainder
  input  logic [WIDTH-1:0] q_i,      // dividend bits still to shift in, quotient bits so far
  input  logic [WIDTH-1:0] m_i,      // divisor
  output logic             valid_o,
  output logic [WIDTH-1:0] acc_o,
  output logic [WIDTH-1:0] q_o,
  output logic [WIDTH-1:0] m_o
);

  logic             valid_r;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] m_r;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  // Shift the next dividend bit in, trial-subtract, restore on borrow.
  always_comb begin
    shifted = {acc_i, q_i[WIDTH-1]};
    diff    = shifted - {1'b0, m_i};
    ge      = ~diff[WIDTH];
    acc_nxt = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    q_nxt   = {q_i[WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
      q_r   <= q_nxt;
      m_r   <= m_i;
    end
  end

  assign valid_o = valid_r;
  assign acc_o   = acc_r;
  assign q_o     = q_r;
  assign m_o     = m_r;

endmodule : rd_stage

// ===== rtl/restoring_divider.sv =====
// Top level of the pipelined unsigned restoring divider, one round per stage.
// Depends on rd_pkg and rd_stage.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready   | tdata: dividend[31:0], divisor[63:32]
//  out_    | out | out_tvalid/out_tready | tdata: quotient[31:0], remainder[63:32];
//          |     |                       | tuser: divide_by_zero[0]
//
// Each transaction passes through WIDTH register stages (32 at the default), one quotient bit
// per stage. The pipe takes a new transaction every cycle while the output is not stalled;
// throughput is one per cycle while no stall holds the pipe.
// A stall on the output freezes every stage at once, so nothing is dropped or repeated.
// rst_n is synchronous and active low; it clears the stage valid bits only.
module restoring_divider
  import rd_pkg::*;
#(
  parameter int unsigned WIDTH = RD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // dividend [31:0], divisor [63:32]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // quotient [31:0], remainder [63:32]
  output logic [OUT_TUSER_W-1:0] out_tuser   // divide_by_zero [0]
);

  // Stage k feeds stage k+1; index 0 is the operand entry, index WIDTH the output.
  logic             valid_s [WIDTH+1];
  logic [WIDTH-1:0] acc_s   [WIDTH+1];
  logic [WIDTH-1:0] q_s     [WIDTH+1];
  logic [WIDTH-1:0] m_s     [WIDTH+1];

  // Zero-extended views used to fit operands and results between
  // the 32-bit fields and the WIDTH-bit datapath.
  logic [WIDTH+FIELD_W-1:0] dividend_ext;
  logic [WIDTH+FIELD_W-1:0] divisor_ext;
  logic [WIDTH+FIELD_W-1:0] quo_ext;
  logic [WIDTH+FIELD_W-1:0] rem_ext;

  logic adv;

  // The pipe moves whenever the output register is empty or being drained.
  assign adv       = ~out_tvalid | out_tready;
  assign in_tready = adv;

  // Drop operand bits at or above WIDTH; zero-fill when WIDTH exceeds the field.
  assign dividend_ext = {{WIDTH{1'b0}}, in_tdata[FIELD_W-1:0]};
  assign divisor_ext  = {{WIDTH{1'b0}}, in_tdata[2*FIELD_W-1:FIELD_W]};

  assign valid_s[0] = in_tvalid;
  assign acc_s[0]   = '0;
  assign q_s[0]     = dividend_ext[WIDTH-1:0];
  assign m_s[0]     = divisor_ext[WIDTH-1:0];

  for (genvar k = 0; k < WIDTH; k++) begin : g_round
    rd_stage #(
      .WIDTH (WIDTH)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (valid_s[k]),
      .acc_i   (acc_s[k]),
      .q_i     (q_s[k]),
      .m_i     (m_s[k]),
      .valid_o (valid_s[k+1]),
      .acc_o   (acc_s[k+1]),
      .q_o     (q_s[k+1]),
      .m_o     (m_s[k+1])
    );
  end

  // The last stage is the output register; fit its contents to the 32-bit fields.
  assign quo_ext = {{FIELD_W{1'b0}}, q_s[WIDTH]};
  assign rem_ext = {{FIELD_W{1'b0}}, acc_s[WIDTH]};

  assign out_tvalid   = valid_s[WIDTH];
  assign out_tdata    = {rem_ext[FIELD_W-1:0], quo_ext[FIELD_W-1:0]};
  assign out_tuser[0] = (m_s[WIDTH] == '0);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic [WIDTH+FIELD_W-1:0] ones_ext;
  assign ones_ext = {{FIELD_W{1'b0}}, {WIDTH{1'b1}}};

  // A divide by zero yields an all-ones quotient.
  a_dbz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[FIELD_W-1:0] == ones_ext[FIELD_W-1:0])
    else $error("divide by zero did not give an all-ones quotient");

  // With a nonzero divisor the remainder ends below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    valid_s[WIDTH] && (m_s[WIDTH] != '0) |-> acc_s[WIDTH] < m_s[WIDTH])
    else $error("remainder not below divisor");

  // While stalled, the middle of the pipe keeps its occupancy.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_s[1]) && $stable(valid_s[WIDTH / 2]))
    else $error("pipe valid bits moved during a stall");

  // An accepted transaction reaches the first stage on the next edge.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> valid_s[1])
    else $error("accepted transaction lost at pipe entry");

endmodule : restoring_divider
